// ===== rtl/core/sdrp_pkg.sv =====
// Shared types and constants of the strict decimal range parser.
`timescale 1ns / 1ps

package sdrp_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd2;

  localparam logic               SIGNED_MODE_RST = 1'b1;
  localparam logic [VALUE_W-1:0] RANGE_LOW_RST   = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] RANGE_HIGH_RST  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_OVERFLOW  = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_MINUS = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_NONE  = 2'd3
  } char_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
    logic       no_char;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic               signed_mode;
    logic [VALUE_W-1:0] range_low;
    logic [VALUE_W-1:0] range_high;
  } cfg_t;

  // Classified character as it travels from the front to the back.
  typedef struct packed {
    char_kind_e kind;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  // Final parse state of one string, handed to the range check.
  typedef struct packed {
    logic [VALUE_W-1:0] magnitude;
    logic               negative;
    logic               digit_seen;
    logic               malformed;
    logic               overflow;
    logic               signed_mode;
  } snap_t;

endpackage

// ===== rtl/core/sdrp_fifo.sv =====
// Small synchronous queue used between the parser stages and for the results.
`timescale 1ns / 1ps

module sdrp_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic rd_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(DEPTH - 1)) res = '0;
    else res = ptr + PTR_W'(1);
    return res;
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (wr_i && !rd_i) count_d = count_q + CNT_W'(1);
    else if (rd_i && !wr_i) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !rd_i |-> !wr_i)
    else $error("write into a full queue");
  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !rd_i)
    else $error("read from an empty queue");
`endif

endmodule

// ===== rtl/core/sdrp_front.sv =====
// Front stage: accepts characters and classifies them for the parse engine.
`timescale 1ns / 1ps

module sdrp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sdrp_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output sdrp_pkg::cmd_t    cmd_o
);

  import sdrp_pkg::*;

  logic first_q, first_d;

  always_comb begin
    cmd_o.last  = item_i.last_char;
    cmd_o.digit = item_i.char_byte[3:0];
    if (item_i.no_char) begin
      cmd_o.kind = KIND_NONE;
    end else if (first_q && item_i.char_byte == MINUS_CHAR) begin
      cmd_o.kind = KIND_MINUS;
    end else if (item_i.char_byte >= ZERO_CHAR && item_i.char_byte <= NINE_CHAR) begin
      cmd_o.kind = KIND_DIGIT;
    end else begin
      cmd_o.kind = KIND_OTHER;
    end
  end

  // An empty beat that does not end the string has no effect and is dropped here.
  assign cmd_push_o = accept_i && (!item_i.no_char || item_i.last_char);

  always_comb begin
    first_d = first_q;
    if (accept_i) begin
      if (item_i.last_char) first_d = 1'b1;
      else if (!item_i.no_char) first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

endmodule

// ===== rtl/core/sdrp_back.sv =====
// Parse engine: builds the magnitude and tracks sign and error flags.
`timescale 1ns / 1ps

module sdrp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  sdrp_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  input  logic            signed_mode_i,
  input  logic            snap_ready_i,
  output logic            snap_push_o,
  output sdrp_pkg::snap_t snap_o
);

  import sdrp_pkg::*;

  localparam logic [VALUE_W-1:0] LIM_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] LIM_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] LIM_UNS = {VALUE_W{1'b1}};

  logic [VALUE_W-1:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic digit_q, digit_d;
  logic mal_q, mal_d;
  logic ovf_q, ovf_d;

  logic [VALUE_W+3:0] acc;
  logic [VALUE_W-1:0] lim;
  logic take;

  assign take        = cmd_valid_i && (!cmd_i.last || snap_ready_i);
  assign cmd_pop_o   = take;
  assign snap_push_o = take && cmd_i.last;

  // magnitude * 10 + digit; this exceeds the limit exactly when the next digit overflows.
  assign acc = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {{VALUE_W{1'b0}}, cmd_i.digit};
  assign lim = !signed_mode_i ? LIM_UNS : (neg_q ? LIM_NEG : LIM_POS);

  always_comb begin
    mag_d   = mag_q;
    neg_d   = neg_q;
    digit_d = digit_q;
    mal_d   = mal_q;
    ovf_d   = ovf_q;
    unique case (cmd_i.kind)
      KIND_MINUS: begin
        if (signed_mode_i) neg_d = 1'b1;
        else mal_d = 1'b1;
      end
      KIND_DIGIT: begin
        digit_d = 1'b1;
        if (!ovf_q) begin
          if (acc > {4'b0, lim}) ovf_d = 1'b1;
          else mag_d = acc[VALUE_W-1:0];
        end
      end
      KIND_OTHER: mal_d = 1'b1;
      KIND_NONE: ;
      default: ;
    endcase
  end

  always_comb begin
    snap_o.magnitude   = mag_d;
    snap_o.negative    = neg_d;
    snap_o.digit_seen  = digit_d;
    snap_o.malformed   = mal_d;
    snap_o.overflow    = ovf_d;
    snap_o.signed_mode = signed_mode_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      digit_q <= 1'b0;
      mal_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (take) begin
      if (cmd_i.last) begin
        mag_q   <= '0;
        neg_q   <= 1'b0;
        digit_q <= 1'b0;
        mal_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        mag_q   <= mag_d;
        neg_q   <= neg_d;
        digit_q <= digit_d;
        mal_q   <= mal_d;
        ovf_q   <= ovf_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cmd_i.last |=> mag_q == '0 && !neg_q && !digit_q && !mal_q && !ovf_q)
    else $error("parse state not cleared after end of string");
  a_snap_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push_o |-> snap_ready_i)
    else $error("snapshot pushed without room");
  a_frozen_after_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !(take && cmd_i.last) |=> $stable(mag_q) && ovf_q)
    else $error("magnitude moved after overflow");
`endif

endmodule

// ===== rtl/core/sdrp_check.sv =====
// Result stage: applies sign, range check and status priority to a finished string.
`timescale 1ns / 1ps

module sdrp_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdrp_pkg::cfg_t    cfg_i,
  input  logic              snap_push_i,
  input  sdrp_pkg::snap_t   snap_i,
  output logic              snap_ready_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output sdrp_pkg::out_item_t res_o
);

  import sdrp_pkg::*;

  snap_t snap_q;
  logic  valid_q;

  logic [VALUE_W-1:0] v;
  logic [VALUE_W-1:0] v_key, lo_key, hi_key;

  assign res_push_o   = valid_q && !res_full_i;
  assign snap_ready_o = !valid_q || !res_full_i;

  assign v = snap_q.negative ? (~snap_q.magnitude + VALUE_W'(1)) : snap_q.magnitude;

  // Flipping the sign bit turns a signed compare into an unsigned one.
  assign v_key  = {v[VALUE_W-1] ^ snap_q.signed_mode, v[VALUE_W-2:0]};
  assign lo_key = {cfg_i.range_low[VALUE_W-1] ^ snap_q.signed_mode,
                   cfg_i.range_low[VALUE_W-2:0]};
  assign hi_key = {cfg_i.range_high[VALUE_W-1] ^ snap_q.signed_mode,
                   cfg_i.range_high[VALUE_W-2:0]};

  always_comb begin
    res_o.value = '0;
    priority if (snap_q.malformed || !snap_q.digit_seen ||
                 (snap_q.negative && !snap_q.signed_mode)) begin
      res_o.status = STATUS_MALFORMED;
    end else if (snap_q.overflow) begin
      res_o.status = STATUS_OVERFLOW;
    end else if (v_key < lo_key || v_key > hi_key) begin
      res_o.status = STATUS_RANGE;
    end else begin
      res_o.status = STATUS_OK;
      res_o.value  = v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_push_i) snap_q <= snap_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (snap_push_i) begin
      valid_q <= 1'b1;
    end else if (res_push_o) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/strict_decimal_range_parser_top.sv =====
// Top level of the strict decimal range parser with its configuration registers.
`timescale 1ns / 1ps

// Parses an ASCII decimal string, one character per input beat, into a 64-bit value
// and reports ok, malformed, overflow or out of range on the beat marked last.
// The block takes one character every cycle while the command queue has room: the
// front classifies each beat into a short command queue, the parse engine retires one
// command per cycle with one multiply-by-ten add, a string's last only while the check
// has room, and finished strings pass through a range-check register into the result
// queue. Input stalls only when the command queue fills behind a full result queue.
// Configuration writes take effect at once and are meant for idle periods.
module strict_decimal_range_parser_top #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  input  sdrp_pkg::in_item_t                     item_i,
  output logic                                   full,
  output logic                                   empty,
  input  logic                                   pop,
  output sdrp_pkg::out_item_t                    result_o,
  input  logic                                   cfg_we_i,
  input  logic [sdrp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [sdrp_pkg::VALUE_W-1:0]           cfg_data_i
);

  import sdrp_pkg::*;

  cfg_t cfg_q;

  logic      accept;
  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_in, cmd_head;
  logic      snap_push, snap_ready;
  snap_t     snap;
  logic      res_push, res_full;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode <= SIGNED_MODE_RST;
      cfg_q.range_low   <= RANGE_LOW_RST;
      cfg_q.range_high  <= RANGE_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIGNED_MODE: cfg_q.signed_mode <= cfg_data_i[0];
        CFG_RANGE_LOW:   cfg_q.range_low   <= cfg_data_i;
        CFG_RANGE_HIGH:  cfg_q.range_high  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  sdrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  sdrp_fifo #(
    .DEPTH (CMD_DEPTH),
    .T     (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  sdrp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!cmd_empty),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .signed_mode_i (cfg_q.signed_mode),
    .snap_ready_i  (snap_ready),
    .snap_push_o   (snap_push),
    .snap_o        (snap)
  );

  sdrp_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .snap_push_i  (snap_push),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  sdrp_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (out_item_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .rd_i    (pop && !empty),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

// ===== sim/sdrp_parse_checker.sv =====
// Checker that predicts the parser's results from the observed beats and compares them.
`timescale 1ns / 1ps

module sdrp_parse_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  sdrp_pkg::in_item_t             item_i,
  input  logic                           pop_i,
  input  logic                           empty_i,
  input  sdrp_pkg::out_item_t            result_i,
  input  logic                           cfg_we_i,
  input  logic [sdrp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdrp_pkg::VALUE_W-1:0]   cfg_data_i,
  output int                             err_cnt_o,
  output int                             pending_o,
  output int                             ok_cnt_o,
  output int                             rej_cnt_o
);

  import sdrp_pkg::*;

  // Register copies, as the block should hold them.
  logic               mode_q;
  logic [VALUE_W-1:0] low_q;
  logic [VALUE_W-1:0] high_q;

  // Parse state of the string in flight.
  logic [VALUE_W-1:0] parse_mag;
  logic               parse_neg;
  logic               parse_first;
  logic               parse_digit;
  logic               parse_bad;
  logic               parse_ovf;

  out_item_t awaited_verdicts[$];

  task automatic clear_string();
    parse_mag   = '0;
    parse_neg   = 1'b0;
    parse_first = 1'b1;
    parse_digit = 1'b0;
    parse_bad   = 1'b0;
    parse_ovf   = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c);
    logic [VALUE_W-1:0] d;
    logic [VALUE_W-1:0] ceiling;
    if (parse_first && c == MINUS_CHAR) begin
      if (mode_q) parse_neg = 1'b1;
      else parse_bad = 1'b1;
    end else if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
      d = 64'(c) - 64'(ZERO_CHAR);
      if (!mode_q) ceiling = {VALUE_W{1'b1}};
      else if (parse_neg) ceiling = 64'h8000_0000_0000_0000;
      else ceiling = 64'h7FFF_FFFF_FFFF_FFFF;
      parse_digit = 1'b1;
      // Once the limit is passed the magnitude stays frozen for the rest of the string.
      if (!parse_ovf) begin
        if (parse_mag > (ceiling - d) / 64'd10) parse_ovf = 1'b1;
        else parse_mag = parse_mag * 64'd10 + d;
      end
    end else begin
      parse_bad = 1'b1;
    end
    parse_first = 1'b0;
  endtask

  task automatic close_string(output out_item_t r);
    logic [VALUE_W-1:0] v;
    logic               below;
    logic               above;
    r.value = '0;
    v = parse_neg ? (64'd0 - parse_mag) : parse_mag;
    if (parse_bad || !parse_digit || (parse_neg && !mode_q)) begin
      r.status = STATUS_MALFORMED;
    end else if (parse_ovf) begin
      r.status = STATUS_OVERFLOW;
    end else begin
      if (mode_q) begin
        below = $signed(v) < $signed(low_q);
        above = $signed(v) > $signed(high_q);
      end else begin
        below = v < low_q;
        above = v > high_q;
      end
      if (below || above) begin
        r.status = STATUS_RANGE;
      end else begin
        r.status = STATUS_OK;
        r.value  = v;
      end
    end
    clear_string();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t verdict;
    out_item_t want;
    int        misses;
    if (!rst_ni) begin
      mode_q = SIGNED_MODE_RST;
      low_q  = RANGE_LOW_RST;
      high_q = RANGE_HIGH_RST;
      clear_string();
      awaited_verdicts.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
      ok_cnt_o  <= 0;
      rej_cnt_o <= 0;
    end else begin
      misses = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIGNED_MODE: mode_q = cfg_data_i[0];
          CFG_RANGE_LOW:   low_q  = cfg_data_i;
          CFG_RANGE_HIGH:  high_q = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        if (!item_i.no_char) take_char(item_i.char_byte);
        if (item_i.last_char) begin
          close_string(verdict);
          awaited_verdicts.insert(awaited_verdicts.size(), verdict);
        end
      end
      if (pop_i && !empty_i) begin
        if (result_i.status == STATUS_OK) ok_cnt_o <= ok_cnt_o + 1;
        else rej_cnt_o <= rej_cnt_o + 1;
        if (awaited_verdicts.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d value %h",
                   $time, result_i.status, result_i.value);
          misses = 1;
        end else begin
          want = awaited_verdicts.pop_front();
          if (want.status !== result_i.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, result_i.status);
            misses = 1;
          end
          if (want.value !== result_i.value) begin
            $display("%0t: value mismatch: expected %h, got %h",
                     $time, want.value, result_i.value);
            misses = 1;
          end
        end
      end
      err_cnt_o <= err_cnt_o + misses;
      pending_o <= awaited_verdicts.size();
    end
  end

endmodule

// ===== sim/strict_decimal_range_parser_top_tb.sv =====
// Testbench top: feeds strings and register settings to the parser and gives the verdict.
`timescale 1ns / 1ps

module strict_decimal_range_parser_top_tb;
  import sdrp_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RX_HOLD_CYCLES = 120;
  localparam int unsigned PHASE_CHARS    = 150;
  localparam int unsigned NUM_PHASES     = 8;

  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef logic [7:0] text_t[$];

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic               empty;
  logic               pop;
  in_item_t           item;
  out_item_t          result;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [VALUE_W-1:0] cfg_data;

  int err_cnt;
  int pending;
  int ok_cnt;
  int rej_cnt;
  int idle_cycles;
  int n_chars;
  int n_strings;
  int n_settings;
  bit calm;
  bit hold_rx;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  strict_decimal_range_parser_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .item_i     (item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sdrp_parse_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .item_i     (item),
    .pop_i      (pop),
    .empty_i    (empty),
    .result_i   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .ok_cnt_o   (ok_cnt),
    .rej_cnt_o  (rej_cnt)
  );

  function automatic logic [7:0] rand_digit();
    return 8'(ZERO_CHAR + $urandom_range(0, 9));
  endfunction

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
    return t;
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic last, input logic none);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    item <= '{char_byte: c, last_char: last, no_char: none};
    do @(posedge clk_i); while (full);
    if (!none) n_chars++;
  endtask

  // Sends one string; empty beats may be slipped in, and the string may be closed by one.
  task automatic send_text(input text_t s, input int none_pct);
    bit close_empty;
    close_empty = (s.size() == 0) || ($urandom_range(0, 99) < none_pct);
    foreach (s[i]) begin
      if ($urandom_range(0, 99) < none_pct) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_beat(s[i], !close_empty && i == s.size() - 1, 1'b0);
    end
    if (close_empty) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    n_strings++;
  endtask

  task automatic send_str(input string s);
    send_text(to_text(s), 0);
  endtask

  // Stops offering beats until every result is out and the pipeline has drained.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input bit mode, input logic [VALUE_W-1:0] lo,
                             input logic [VALUE_W-1:0] hi);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SIGNED_MODE;
    cfg_data <= {63'd0, mode};
    @(posedge clk_i);
    cfg_idx  <= CFG_RANGE_LOW;
    cfg_data <= lo;
    @(posedge clk_i);
    cfg_idx  <= CFG_RANGE_HIGH;
    cfg_data <= hi;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  task automatic write_mode(input bit mode);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SIGNED_MODE;
    cfg_data <= {63'd0, mode};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  function automatic text_t make_string(input bit mode);
    text_t s;
    string base;
    int    kind;
    int    n;
    int    pos;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if (mode && $urandom_range(0, 2) == 0) s.insert(s.size(), MINUS_CHAR);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 22) : $urandom_range(1, 4);
      repeat (n) s.insert(s.size(), rand_digit());
    end else if (kind < 80) begin
      // Strings right at the edge of the 64-bit limits.
      if (!mode) base = "18446744073709551615";
      else if ($urandom_range(0, 1) == 1) base = "-9223372036854775808";
      else base = "9223372036854775807";
      s = to_text(base);
      s[s.size() - 1] = rand_digit();
      if ($urandom_range(0, 3) == 0) s[s.size() - 2] = rand_digit();
      if ($urandom_range(0, 7) == 0) s.insert(s.size(), rand_digit());
      if ($urandom_range(0, 5) == 0) s.insert((s[0] == MINUS_CHAR) ? 1 : 0, ZERO_CHAR);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 3)) s.insert(s.size(), rand_digit());
      pos = $urandom_range(0, s.size());
      case ($urandom_range(0, 3))
        0:       s.insert(pos, MINUS_CHAR);
        1:       s.insert(pos, PLUS_CHAR);
        2:       s.insert(pos, SPACE_CHAR);
        default: s.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end else begin
      repeat ($urandom_range(0, 5)) s.insert(s.size(), 8'($urandom_range(0, 255)));
    end
    return s;
  endfunction

  task automatic run_directed();
    send_str("0");
    send_str("-0");
    send_str("9223372036854775807");
    send_str("-9223372036854775808");
    send_str("9223372036854775808");
    send_str("-9223372036854775809");
    send_str("");
    send_str("-");
    send_str("+5");
    send_str(" 7");
    send_str("4-2");
    send_str("--1");
    // Bad character after an overflow: malformed wins.
    send_str("99999999999999999999z");
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    n_strings += 2;
    // An empty beat in the middle is ignored, whatever byte it carries.
    send_beat("1", 1'b0, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b1);
    send_beat("2", 1'b1, 1'b0);
    // A string closed by an empty beat.
    send_beat("3", 1'b0, 1'b0);
    send_beat(8'h5A, 1'b1, 1'b1);
    n_strings += 2;

    load_config(1'b0, '0, {VALUE_W{1'b1}});
    send_str("18446744073709551615");
    send_str("18446744073709551616");
    send_str("-1");
    send_str("0");

    load_config(1'b1, -64'sd100, 64'd100);
    send_str("-101");
    send_str("-100");
    send_str("100");
    send_str("101");
    send_str("99999999999999999999");

    load_config(1'b0, 64'd10, 64'd20);
    send_str("9");
    send_str("21");
    send_str("15");

    // Mode flipped between the beats of one string.
    load_config(1'b1, RANGE_LOW_RST, RANGE_HIGH_RST);
    send_beat(MINUS_CHAR, 1'b0, 1'b0);
    write_mode(1'b0);
    send_beat("5", 1'b1, 1'b0);
    send_beat("7", 1'b0, 1'b0);
    write_mode(1'b1);
    send_beat(MINUS_CHAR, 1'b1, 1'b0);
    n_strings += 2;
  endtask

  task automatic run_random();
    bit                 mode;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    int                 stop;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin mode = 1'b1; lo = RANGE_LOW_RST; hi = RANGE_HIGH_RST; end
        1: begin mode = 1'b0; lo = '0; hi = {VALUE_W{1'b1}}; end
        2: begin
          mode = 1'b1;
          lo = 64'd0 - 64'($urandom_range(0, 5000));
          hi = 64'($urandom_range(0, 5000));
        end
        3: begin
          mode = 1'b0;
          lo = 64'($urandom_range(0, 50));
          hi = 64'($urandom_range(50, 100000));
        end
        4: begin mode = 1'b1; lo = 64'($urandom_range(0, 9)); hi = lo; end
        5: begin mode = 1'b0; lo = {VALUE_W{1'b1}}; hi = '0; end
        6: begin mode = 1'b1; lo = RANGE_LOW_RST; hi = 64'($urandom); end
        default: begin
          mode = 1'($urandom_range(0, 1));
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      load_config(mode, lo, hi);
      // Starve the result side once so the block backs up and stalls the input.
      if (phase == 2) hold_rx = 1'b1;
      stop = n_chars + PHASE_CHARS;
      while (n_chars < stop) begin
        if ($urandom_range(0, 19) == 0) calm = !calm;
        send_text(make_string(mode), 5);
      end
    end
  endtask

  initial begin : drain_results
    int gap;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("strict_decimal_range_parser_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    push       = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_rx    = 1'b0;
    n_chars    = 0;
    n_strings  = 0;
    n_settings = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    settle();
    $display("Sent %0d characters in %0d strings under %0d register settings.",
             n_chars, n_strings, n_settings);
    $display("Checked %0d parsed values and %0d rejected strings.", ok_cnt, rej_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("strict_decimal_range_parser_top_tb: clean");
    end else begin
      $display("strict_decimal_range_parser_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== strict_decimal_range_parser_top.f =====
rtl/core/sdrp_pkg.sv
rtl/core/sdrp_fifo.sv
rtl/core/sdrp_front.sv
rtl/core/sdrp_back.sv
rtl/core/sdrp_check.sv
rtl/core/strict_decimal_range_parser_top.sv
sim/sdrp_parse_checker.sv
sim/strict_decimal_range_parser_top_tb.sv
